// ===== rtl/core/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter package
// Request kinds, shift control for the stack cells and precedence helpers.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Kind of an accepted request, decided when it is taken in.
   localparam logic [1:0] KIND_LETTER = 2'd0;
   localparam logic [1:0] KIND_RPAR   = 2'd1;
   localparam logic [1:0] KIND_OPER   = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_LPAR   = 8'h28;
   localparam logic [7:0] CHAR_RPAR   = 8'h29;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_Z      = 8'h5A;

   // Shift command broadcast along the row of stack cells.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         p = 2'd1;
      end else if (c == CHAR_STAR || c == CHAR_SLASH) begin
         p = 2'd2;
      end else if (c == CHAR_LPAR) begin
         p = 2'd3;
      end else begin
         p = 2'd0;
      end
      return p;
   endfunction

   function automatic logic [1:0] classify(input logic func, input logic [7:0] c);
      logic [1:0] k;
      if (func) begin
         k = KIND_END;
      end else if (c >= CHAR_A && c <= CHAR_Z) begin
         k = KIND_LETTER;
      end else if (c == CHAR_RPAR) begin
         k = KIND_RPAR;
      end else begin
         k = KIND_OPER;
      end
      return k;
   endfunction

   // True when an entry x, present if nonempty is set, is to be popped and emitted.
   function automatic logic pop_cond(input logic [1:0] kind, input logic [7:0] sym,
                                     input logic [7:0] x, input logic nonempty);
      logic r;
      case (kind)
         KIND_END:  r = nonempty;
         KIND_RPAR: r = nonempty && (x != CHAR_LPAR);
         KIND_OPER: r = nonempty && (x != CHAR_LPAR) && (prec_of(sym) <= prec_of(x));
         default:   r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/itp_if.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter channels
// Valid/ready interfaces for the character requests and the postfix results.
// ----------------------------------------------------------------------------
interface itp_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] symbol;

   modport source (output valid, output func, output symbol, input ready);
   modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       has_char;
   logic       run_last;
   logic       expr_end;
   logic       overflow;

   modport source (output valid, output out_char, output has_char, output run_last,
                   output expr_end, output overflow, input ready);
   modport sink   (input valid, input out_char, input has_char, input run_last,
                   input expr_end, input overflow, output ready);
endinterface

// ===== rtl/core/itp_cell.sv =====
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the shift-register operator stack. A push takes the entry
// above, a pop takes the entry below.
// ----------------------------------------------------------------------------
module itp_cell (
   input  logic                  clock,
   input  itp_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]            up_data,
   input  logic [7:0]            down_data,
   output logic [7:0]            data
);
   import itp_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // Shift towards the bottom on a push and towards the top on a pop.
   always_comb begin
      data_in = data_ff;
      if (ctrl.push) begin
         data_in = up_data;
      end else if (ctrl.pop) begin
         data_in = down_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/core/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter
// Shunting-yard conversion with the operator stack held in a row of cells.
// ----------------------------------------------------------------------------
// The first result of a request is registered at the first step after the
// request is accepted. A new request is taken only once the last one is done:
// the sequencer pops and emits stack entries one per step, and each pop shifts
// the cell row once; a closing step then ends the request.
// A full output register that is not taken stalls the sequencer.
// Reset (synchronous) empties the stack and clears the output valid.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   itp_req_if.sink   req_ch,
   itp_rsp_if.source rsp_ch
);
   import itp_pkg::*;

   localparam int CntW = $clog2(STACK_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   logic            state_ff, state_in;
   logic [1:0]      kind_ff, kind_in;
   logic [7:0]      sym_ff, sym_in;
   logic            emitted_ff, emitted_in;
   logic [CntW-1:0] count_ff, count_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_has_ff, rsp_has_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_end_ff, rsp_end_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   cell_ctrl_type   ctrl;
   logic [7:0]      cell_data [STACK_DEPTH];
   logic [7:0]      top_char;
   logic [7:0]      next_char;
   logic            cnt_nz, cnt_gt1, full;
   logic            cond_top, cond_next;
   logic            req_take, rsp_free, step, load_rsp;

   // Row of stack cells; cell zero is the top of stack.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [7:0] up_d;
      logic [7:0] down_d;
      if (i == 0) begin : g_top
         assign up_d = sym_ff;
      end else begin : g_mid
         assign up_d = cell_data[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign down_d = 8'h00;
      end else begin : g_low
         assign down_d = cell_data[i+1];
      end
      itp_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .up_data   (up_d),
         .down_data (down_d),
         .data      (cell_data[i])
      );
   end

   // Look at the top two entries to know whether the current pop is the last.
   assign top_char  = cell_data[0];
   assign next_char = cell_data[1];
   assign cnt_nz    = count_ff != '0;
   assign cnt_gt1   = count_ff > CntW'(1);
   assign full      = count_ff == CntW'(STACK_DEPTH);
   assign cond_top  = pop_cond(kind_ff, sym_ff, top_char, cnt_nz);
   assign cond_next = pop_cond(kind_ff, sym_ff, next_char, cnt_gt1);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign step         = (state_ff == ST_WORK) && rsp_free;

   // Sequencer: one pop per step, then the closing action of the request.
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      sym_in      = sym_ff;
      emitted_in  = emitted_ff;
      count_in    = count_ff;
      ctrl        = '0;
      load_rsp    = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_has_in  = rsp_has_ff;
      rsp_last_in = rsp_last_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      if (req_take) begin
         state_in   = ST_WORK;
         kind_in    = classify(req_ch.func, req_ch.symbol);
         sym_in     = req_ch.symbol;
         emitted_in = 1'b0;
      end else if (step) begin
         if (cond_top) begin
            ctrl.pop    = 1'b1;
            count_in    = count_ff - CntW'(1);
            emitted_in  = 1'b1;
            load_rsp    = 1'b1;
            rsp_char_in = top_char;
            rsp_has_in  = 1'b1;
            rsp_last_in = !cond_next;
            rsp_end_in  = !cond_next && (kind_ff == KIND_END);
            rsp_ovf_in  = 1'b0;
         end else begin
            state_in = ST_IDLE;
            if (kind_ff == KIND_RPAR && cnt_nz) begin
               ctrl.pop = 1'b1;
               count_in = count_ff - CntW'(1);
            end else if (kind_ff == KIND_OPER && !full) begin
               ctrl.push = 1'b1;
               count_in  = count_ff + CntW'(1);
            end
            if (!emitted_ff) begin
               load_rsp    = 1'b1;
               rsp_has_in  = (kind_ff == KIND_LETTER);
               rsp_char_in = (kind_ff == KIND_LETTER) ? sym_ff : 8'h00;
               rsp_last_in = 1'b1;
               rsp_end_in  = (kind_ff == KIND_END);
               rsp_ovf_in  = (kind_ff == KIND_OPER) && full;
            end
         end
      end
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sym_ff      <= sym_in;
      rsp_char_ff <= rsp_char_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_char = rsp_char_ff;
   assign rsp_ch.has_char = rsp_has_ff;
   assign rsp_ch.run_last = rsp_last_ff;
   assign rsp_ch.expr_end = rsp_end_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

endmodule

// ===== rtl/core/itp_checker.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_char,
   input logic       has_char,
   input logic       run_last,
   input logic       expr_end,
   input logic       overflow
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_char) && $stable(has_char)
         && $stable(run_last) && $stable(expr_end) && $stable(overflow))
      else $error("result changed while stalled");

   // One request at a time: no acceptance straight after an acceptance.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is in progress");

   // An empty result carries a zero character.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_char |-> out_char == 8'h00)
      else $error("empty result with nonzero character");

   // The end mark only sits on the last result of a request.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && expr_end |-> run_last)
      else $error("end of expression on a result that is not last");

   // A dropped push pops nothing, so it is a single empty result.
   a_ovf_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow |-> run_last && !has_char && !expr_end)
      else $error("overflow on a result carrying a character");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_char  (rsp_ch.out_char),
   .has_char  (rsp_ch.has_char),
   .run_last  (rsp_ch.run_last),
   .expr_end  (rsp_ch.expr_end),
   .overflow  (rsp_ch.overflow)
);

// ===== test/infix_to_postfix_converter_tb.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter testbench
// Sends infix characters and end marks through the request channel. A
// shunting-yard model in the testbench works out the postfix results that
// each request should give, and the monitor checks every result against them
// in order. Both channels idle at random, and the result side holds off once
// for a long stretch so that the converter backs up and stalls its input.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;
   import itp_pkg::*;

   localparam int         STACK_DEPTH  = 32;
   localparam int         RANDOM_ITEMS = 195;
   localparam int         CALM_TAIL    = 30;
   localparam int         STALL_CYCLES = 150;
   localparam logic       FUNC_CHAR    = 1'b0;
   localparam logic       FUNC_END     = 1'b1;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic       func;
      logic [7:0] symbol;
   } infix_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       run_last;
      logic       expr_end;
      logic       overflow;
   } postfix_type;

   logic clock = 1'b0;
   logic reset;
   logic hold_rsp = 1'b0;

   infix_req_type infix_pending [$];
   postfix_type   postfix_due [$];
   logic [7:0]    op_model [STACK_DEPTH];
   int            op_depth = 0;
   int            requests_taken = 0;
   int            request_total = 0;
   int            fault_count = 0;
   int            send_gap = 0;
   int            take_gap = 0;

   itp_req_if req_if ();
   itp_rsp_if rsp_if ();

   infix_to_postfix_converter #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Operator precedence as the conversion uses it.
   function automatic logic [1:0] rank_of(input logic [7:0] c);
      logic [1:0] r;
      case (c)
         CHAR_PLUS, CHAR_MINUS: r = 2'd1;
         CHAR_STAR, CHAR_SLASH: r = 2'd2;
         CHAR_LPAR:             r = 2'd3;
         default:               r = 2'd0;
      endcase
      return r;
   endfunction

   // Shunting-yard step: queues the postfix results that one request releases.
   function automatic void shunt_request(input logic is_end, input logic [7:0] sym);
      logic        is_letter;
      logic        is_close;
      logic        popping;
      logic        spill;
      logic        have;
      logic [1:0]  lvl;
      logic [7:0]  top;
      postfix_type held;
      is_letter = !is_end && sym >= CHAR_A && sym <= CHAR_Z;
      is_close  = !is_end && sym == CHAR_RPAR;
      lvl       = rank_of(sym);
      popping   = !is_letter;
      spill     = 1'b0;
      have      = 1'b0;
      held      = '0;
      // Release stacked operators while the request calls for it.
      while (popping && op_depth > 0) begin
         top = op_model[op_depth - 1];
         if (!is_end && (top == CHAR_LPAR || (!is_close && lvl > rank_of(top)))) begin
            popping = 1'b0;
         end else begin
            if (have) begin
               postfix_due.push_back(held);
            end
            held          = '0;
            held.out_char = top;
            held.has_char = 1'b1;
            have          = 1'b1;
            op_depth--;
         end
      end
      // Then the request's own effect on the output and the stack.
      if (is_letter) begin
         held          = '0;
         held.out_char = sym;
         held.has_char = 1'b1;
         have          = 1'b1;
      end else if (is_close) begin
         if (op_depth > 0) begin
            op_depth--;
         end
      end else if (!is_end) begin
         if (op_depth < STACK_DEPTH) begin
            op_model[op_depth] = sym;
            op_depth++;
         end else begin
            spill = 1'b1;
         end
      end
      if (!have) begin
         held = '0;
      end
      held.run_last = 1'b1;
      held.expr_end = is_end;
      held.overflow = spill;
      postfix_due.push_back(held);
   endfunction

   task automatic add_request(input logic f, input logic [7:0] s);
      infix_req_type r;
      r.func   = f;
      r.symbol = s;
      infix_pending.push_back(r);
   endtask

   // A well-formed expression with random letters, operators and brackets.
   task automatic add_expression(input int terms);
      int open;
      int k;
      open = 0;
      for (k = 0; k < terms; k++) begin
         while (open < 6 && $urandom_range(0, 3) == 0) begin
            add_request(FUNC_CHAR, CHAR_LPAR);
            open++;
         end
         add_request(FUNC_CHAR, CHAR_A + 8'($urandom_range(0, 25)));
         while (open > 0 && $urandom_range(0, 2) == 0) begin
            add_request(FUNC_CHAR, CHAR_RPAR);
            open--;
         end
         if (k < terms - 1) begin
            case ($urandom_range(0, 3))
               0:       add_request(FUNC_CHAR, CHAR_PLUS);
               1:       add_request(FUNC_CHAR, CHAR_MINUS);
               2:       add_request(FUNC_CHAR, CHAR_STAR);
               default: add_request(FUNC_CHAR, CHAR_SLASH);
            endcase
         end
      end
      while (open > 0) begin
         add_request(FUNC_CHAR, CHAR_RPAR);
         open--;
      end
      add_request(FUNC_END, 8'($urandom_range(0, 255)));
   endtask

   // Deep bracket nesting; beyond the stack depth the pushes are dropped.
   task automatic add_nest(input int levels);
      int k;
      for (k = 0; k < levels; k++) begin
         add_request(FUNC_CHAR, CHAR_LPAR);
      end
      add_request(FUNC_CHAR, CHAR_Z);
      for (k = $urandom_range(0, 3); k > 0; k--) begin
         add_request(FUNC_CHAR, CHAR_RPAR);
      end
      add_request(FUNC_END, 8'($urandom_range(0, 255)));
   endtask

   // Loose characters and stray end marks that break the expression shape.
   task automatic add_noise(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 7) == 0) begin
            add_request(FUNC_END, 8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0:       add_request(FUNC_CHAR, CHAR_LPAR);
               1:       add_request(FUNC_CHAR, CHAR_RPAR);
               default: add_request(FUNC_CHAR, 8'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   // Request driver: offers queued requests, with bursts of idle cycles.
   always @(posedge clock) begin : request_driver
      logic          offer;
      infix_req_type head;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            shunt_request(req_if.func, req_if.symbol);
            requests_taken++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (infix_pending.size() > 0) begin
               head = infix_pending.pop_front();
               req_if.func   <= head.func;
               req_if.symbol <= head.symbol;
               offer = 1'b1;
               if (infix_pending.size() >= CALM_TAIL && $urandom_range(0, 3) == 0) begin
                  send_gap = $urandom_range(1, 8);
               end
            end
         end
         req_if.valid <= offer;
      end
   end

   // Result monitor: checks each result against the oldest expectation.
   always @(posedge clock) begin : result_monitor
      postfix_type seen;
      postfix_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.out_char = rsp_if.out_char;
            seen.has_char = rsp_if.has_char;
            seen.run_last = rsp_if.run_last;
            seen.expr_end = rsp_if.expr_end;
            seen.overflow = rsp_if.overflow;
            if (postfix_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected result: out_char=%h has_char=%b ",
                           seen.out_char, seen.has_char,
                           "run_last=%b expr_end=%b overflow=%b",
                           seen.run_last, seen.expr_end, seen.overflow);
               end
            end else begin
               want = postfix_due.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("result mismatch (expected/actual): ",
                              "out_char %h/%h has_char %b/%b ",
                              want.out_char, seen.out_char,
                              want.has_char, seen.has_char,
                              "run_last %b/%b expr_end %b/%b overflow %b/%b",
                              want.run_last, seen.run_last,
                              want.expr_end, seen.expr_end,
                              want.overflow, seen.overflow);
                  end
               end
            end
         end
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (infix_pending.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
               take_gap = $urandom_range(1, 8);
            end
         end
      end
   end

   // One long hold-off on the result side while requests keep coming.
   initial begin : result_stall
      while (requests_taken < 60) begin
         @(posedge clock);
      end
      hold_rsp <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      #800000;
      $display("[infix_to_postfix_converter] ERROR");
      $finish;
   end

   initial begin : stimulus
      int pick;
      int first_random;
      reset = 1'b1;

      // Directed part: close on an empty stack, precedence pops, odd codes.
      add_request(FUNC_CHAR, CHAR_RPAR);
      add_request(FUNC_CHAR, CHAR_LPAR);
      add_request(FUNC_CHAR, CHAR_Z);
      add_request(FUNC_CHAR, CHAR_SLASH);
      add_request(FUNC_CHAR, CHAR_A);
      add_request(FUNC_CHAR, CHAR_RPAR);
      add_request(FUNC_CHAR, CHAR_STAR);
      add_request(FUNC_CHAR, CHAR_MINUS);
      add_request(FUNC_CHAR, CHAR_SPACE);
      add_request(FUNC_CHAR, 8'h00);
      add_request(FUNC_CHAR, 8'hFF);
      add_request(FUNC_CHAR, CHAR_PLUS);
      add_request(FUNC_CHAR, CHAR_LPAR);
      add_request(FUNC_CHAR, CHAR_RPAR);
      add_request(FUNC_CHAR, CHAR_STAR);
      // A close with no open bracket left empties the stack.
      add_request(FUNC_CHAR, CHAR_RPAR);
      add_request(FUNC_END, 8'hFF);
      add_request(FUNC_CHAR, CHAR_AT);
      add_request(FUNC_CHAR, CHAR_LBRACK);
      add_request(FUNC_END, 8'h00);
      add_request(FUNC_END, 8'h00);
      add_request(FUNC_CHAR, CHAR_LOWER_A);
      add_request(FUNC_END, 8'h5A);

      // Random part, mostly whole expressions; at least one nest overfills the stack.
      first_random = infix_pending.size();
      add_nest(STACK_DEPTH + 4);
      while (infix_pending.size() < first_random + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            add_expression($urandom_range(1, 6));
         end else if (pick == 14) begin
            add_nest($urandom_range(24, 40));
         end else begin
            add_noise($urandom_range(1, 6));
         end
      end
      request_total = infix_pending.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < request_total || postfix_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("[infix_to_postfix_converter] OK");
      end else begin
         $display("[infix_to_postfix_converter] ERROR");
      end
      $finish;
   end

endmodule
